[hdl/esort_pkg.sv]
// Package for the exchange sort engine.
// Holds the store geometry and data width; no dependencies.
`default_nettype none

package esort_pkg;

    localparam int DEPTH = 64;
    localparam int DW    = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

endpackage

`default_nettype wire

[hdl/esort_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module esort_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/exchange_sort_engine.sv]
// Exchange sort engine. Loads one value per request; the request marked last starts the sort,
// one compare-swap per cycle in S_CMP, bounded by the single read port of the store RAM.
// Results then leave one at a time: each is read (S_ERD) and presented (S_EOUT) before the
// next read, and a stalled output holds the engine in S_EOUT.
// Reset (rst_n, async, active low) clears count, indices, state and output valid;
// store contents stay undefined until written. Uses esort_pkg and esort_ram.
`default_nettype none

module exchange_sort_engine (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [esort_pkg::DW-1:0] value,
    input  wire logic                   last,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [esort_pkg::DW-1:0] value_res,
    output logic                        last_res,
    output logic                        dropped
);

    import esort_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RDA,
        S_LDA,
        S_CMP,
        S_WRA,
        S_ERD,
        S_EOUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic [DW-1:0] a_reg, a_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] value_res_reg;
    logic          last_res_reg;
    logic          dropped_reg;
    logic          load_out;
    logic          k_is_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    esort_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;
    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;
    assign dropped   = dropped_reg;
    assign k_is_last = ((CW'(k_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        load_out   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        i_next     = '0;
                        state_next = S_RDA;
                    end
                end
            end
            S_RDA:
            begin
                if ((CW'(i_reg) + CW'(1)) >= count_reg)
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg;
                    state_next = S_LDA;
                end
            end
            S_LDA:
            begin
                a_next     = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = i_reg + AW'(1);
                j_next     = i_reg + AW'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // a_reg holds the running minimum for position i
                if (a_reg > ram_rdata)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = a_reg;
                    a_next    = ram_rdata;
                end
                if ((CW'(j_reg) + CW'(1)) < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = j_reg + AW'(1);
                    j_next    = j_reg + AW'(1);
                end
                else
                begin
                    state_next = S_WRA;
                end
            end
            S_WRA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = a_reg;
                i_next     = i_reg + AW'(1);
                state_next = S_RDA;
            end
            S_ERD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = k_reg;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out = 1'b1;
                    if (k_is_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        out_valid_next = load_out | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            a_reg         <= '0;
            out_valid_reg <= 1'b0;
            value_res_reg <= '0;
            last_res_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            a_reg         <= a_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                value_res_reg <= ram_rdata;
                last_res_reg  <= k_is_last;
                dropped_reg   <= ovf_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("store count exceeds depth");

    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write to the same entry in one cycle");

    a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ((CW'(j_reg) < count_reg) && (i_reg < j_reg)))
        else $error("compare indices out of order or range");

    a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && k_is_last) |=> ((state_reg == S_LOAD) && (count_reg == '0)
            && out_valid_reg && last_res_reg))
        else $error("final result did not close the set");
`endif

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for exchange_sort_engine: drives value sets and checks the sorted results.
// It predicts each set with its own exchange sort and compares each result field by field.
// Depends on esort_pkg and the exchange_sort_engine RTL.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import esort_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        logic          dropped;
    } sorted_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [DW-1:0] value = '0;
    logic          last = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [DW-1:0] value_res;
    logic          last_res;
    logic          dropped;

    sorted_result_t sorted_q[$];
    logic [DW-1:0]  loaded_q[$];
    logic           loaded_overflow = 1'b0;
    int             error_count = 0;
    int             cycle_count = 0;
    int             random_requests = 0;
    bit             sender_gaps = 1'b1;
    bit             receiver_gaps = 1'b1;

    exchange_sort_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_res (value_res),
        .last_res  (last_res),
        .dropped   (dropped)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= receiver_gaps && ($urandom_range(99) < 33);
    end

    // Predictor: store values of the open set, sort and queue results when it closes.
    task automatic absorb_request(input logic [DW-1:0] v, input logic l);
        logic [DW-1:0]  work[DEPTH];
        logic [DW-1:0]  tmp;
        sorted_result_t r;
        int             n;
        begin
            if (loaded_q.size() < DEPTH)
                loaded_q.push_back(v);
            else
                loaded_overflow = 1'b1;
            if (l)
            begin
                n = loaded_q.size();
                for (int k = 0; k < n; k++)
                    work[k] = loaded_q[k];
                for (int i = 0; i < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (work[i] > work[j])
                        begin
                            tmp = work[i];
                            work[i] = work[j];
                            work[j] = tmp;
                        end
                for (int k = 0; k < n; k++)
                begin
                    r.value = work[k];
                    r.last = (k == n - 1);
                    r.dropped = loaded_overflow;
                    sorted_q.push_back(r);
                end
                loaded_q.delete();
                loaded_overflow = 1'b0;
            end
        end
    endtask

    // Returns at the accepting edge with valid still high.
    task automatic send_request(input logic [DW-1:0] v, input logic l);
        begin
            @(negedge clk);
            while (sender_gaps && ($urandom_range(99) < 33))
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid = 1'b1;
            value = v;
            last = l;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            absorb_request(v, l);
        end
    endtask

    task automatic end_requests();
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic wait_drained();
        begin
            end_requests();
            while (sorted_q.size() != 0)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sorted_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, %s %h last %b dropped %b",
                         $time, "actual value_res", value_res, last_res, dropped);
                error_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (value_res !== want.value)
                begin
                    $display("%0t: value_res mismatch: expected %h, actual %h",
                             $time, want.value, value_res);
                    error_count++;
                end
                if (last_res !== want.last)
                begin
                    $display("%0t: last_res mismatch: expected %b, actual %b",
                             $time, want.last, last_res);
                    error_count++;
                end
                if (dropped !== want.dropped)
                begin
                    $display("%0t: dropped mismatch: expected %b, actual %b",
                             $time, want.dropped, dropped);
                    error_count++;
                end
            end
        end
    end

    task automatic test_single_value_sets();
        begin
            send_request(16'h0000, 1'b1);
            send_request(16'hFFFF, 1'b1);
        end
    endtask

    task automatic test_extreme_values();
        begin
            send_request(16'hFFFF, 1'b0);
            send_request(16'h0000, 1'b0);
            send_request(16'hAAAA, 1'b0);
            send_request(16'h5555, 1'b0);
            send_request(16'h0001, 1'b0);
            send_request(16'h8000, 1'b1);
        end
    endtask

    task automatic test_duplicates();
        begin
            send_request(16'd7, 1'b0);
            send_request(16'd7, 1'b0);
            send_request(16'd3, 1'b0);
            send_request(16'd7, 1'b0);
            send_request(16'd3, 1'b1);
        end
    endtask

    task automatic test_descending();
        begin
            for (int k = 5; k >= 0; k--)
                send_request(16'(k * 1000 + 9), k == 0);
        end
    endtask

    task automatic test_full_store();
        begin
            for (int k = 0; k < DEPTH; k++)
                send_request(16'($urandom), k == DEPTH - 1);
        end
    endtask

    // last arrives on a request that no longer fits
    task automatic test_overflow();
        begin
            for (int k = 0; k < DEPTH + 6; k++)
                send_request(16'($urandom), k == DEPTH + 5);
            send_request(16'h1234, 1'b0);
            send_request(16'h0042, 1'b1);
        end
    endtask

    task automatic test_random_sets();
        int set_size;
        int set_index;
        bit dup_pool;
        begin
            set_index = 0;
            while (random_requests < 25)
            begin
                sender_gaps = !(set_index >= 1 && set_index <= 4);
                receiver_gaps = sender_gaps;
                if ($urandom_range(9) == 0)
                    set_size = $urandom_range(9, 16);
                else
                    set_size = $urandom_range(1, 8);
                dup_pool = ($urandom_range(3) == 0);
                for (int k = 0; k < set_size; k++)
                begin
                    if (dup_pool)
                        send_request(16'($urandom_range(3)), k == set_size - 1);
                    else
                        send_request(16'($urandom), k == set_size - 1);
                    random_requests++;
                end
                set_index++;
            end
            sender_gaps = 1'b1;
            receiver_gaps = 1'b1;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_value_sets();
        test_extreme_values();
        test_duplicates();
        test_descending();
        test_full_store();
        test_overflow();
        test_random_sets();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hdl/esort_pkg.sv
hdl/esort_ram.sv
hdl/exchange_sort_engine.sv
bench/tb_top.sv
